@@ hdl/segment_map_edit_and_translate_top_macros.svh @@
// Assertion macros for the segment map editor and translator.
// No dependencies; included by the files that carry assertions.
`ifndef SEGMENT_MAP_EDIT_AND_TRANSLATE_TOP_MACROS_SVH
`define SEGMENT_MAP_EDIT_AND_TRANSLATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define SMET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset
`define SMET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SMET_ASSERT_IMP(lbl, ante, cons, msg)
`define SMET_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/smet_pkg.sv @@
// Types and codes shared by the segment map editor and translator.
// No dependencies.
package smet_pkg;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_INV   = 3'd1,
    OP_DEL   = 3'd2,
    OP_INS   = 3'd3,
    OP_DUP   = 3'd4,
    OP_QUERY = 3'd5
  } opcode_e;

  localparam logic [1:0] KIND_NORMAL   = 2'd0;
  localparam logic [1:0] KIND_INVERTED = 2'd1;
  localparam logic [1:0] KIND_INSERTED = 2'd2;
  localparam logic [1:0] KIND_DUPLIC   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_COVER = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  localparam int unsigned FIELD_W = 31;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [4:0]         chrom;
    logic [FIELD_W-1:0] left_pos;
    logic [FIELD_W-1:0] right_pos;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] piece_start;
    logic [FIELD_W-1:0] piece_length;
    logic [1:0]         piece_kind;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // One table entry as stored in the segment memory
  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] seg_end;
    logic [FIELD_W-1:0] seg_start;
  } seg_entry_t;

  // Memory strobes from the sequencer
  typedef struct packed {
    logic seg_we;
    logic seg_re;
    logic cnt_we;
    logic cnt_re;
  } mem_ctl_t;

  function automatic logic [FIELD_W-1:0] entry_len(input seg_entry_t v);
    return (v.seg_end >= v.seg_start) ? (v.seg_end - v.seg_start)
                                      : (v.seg_start - v.seg_end);
  endfunction

endpackage

@@ hdl/smet_ram.sv @@
// Simple dual-port synchronous memory with a registered read.
// No dependencies.
module smet_ram #(
  parameter int unsigned DW    = 64,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/smet_ctrl.sv @@
// Sequencer for table edits and position queries, with the result register.
// Depends on smet_pkg and the assertion macros header.
`include "segment_map_edit_and_translate_top_macros.svh"
module smet_ctrl
  import smet_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned MAX_CHROMS   = 32,
  parameter int unsigned POS_BITS     = 31,
  parameter int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1),
  parameter int unsigned CH_W         = (MAX_CHROMS > 1) ? $clog2(MAX_CHROMS) : 1,
  parameter int unsigned ADDR_W       = $clog2(MAX_CHROMS * MAX_SEGMENTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  output mem_ctl_t          mc,
  output logic [ADDR_W-1:0] seg_waddr,
  output seg_entry_t        seg_wdata,
  output logic [ADDR_W-1:0] seg_raddr,
  input  seg_entry_t        seg_rdata,
  output logic [CH_W-1:0]   cnt_waddr,
  output logic [CNT_W-1:0]  cnt_wdata,
  output logic [CH_W-1:0]   cnt_raddr,
  input  logic [CNT_W-1:0]  cnt_rdata
);

  localparam int unsigned ACC_W = FIELD_W + CNT_W;
  localparam logic [FIELD_W-1:0] POS_MASK = FIELD_MAX >> (FIELD_W - POS_BITS);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_INIT  = 14'b00000000000010,
    S_CNT   = 14'b00000000000100,
    S_SRD   = 14'b00000000001000,
    S_SCHK  = 14'b00000000010000,
    S_PLAN  = 14'b00000000100000,
    S_TRD   = 14'b00000001000000,
    S_TWR   = 14'b00000010000000,
    S_NWR   = 14'b00000100000000,
    S_QRD   = 14'b00001000000000,
    S_QACC  = 14'b00010000000000,
    S_QCHK  = 14'b00100000000000,
    S_PCALC = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [FIELD_W-1:0]  lp_r, lp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt, i_r, i_nxt, f_r, f_nxt, idx_r, idx_nxt;
  logic [FIELD_W-1:0]  os_r, os_nxt, oe_r, oe_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt, qbase_r, qbase_nxt;
  logic [FIELD_W-1:0]  rem_r, rem_nxt, diff_r, diff_nxt;
  logic [1:0]          j_r, j_nxt;
  logic                more_r, more_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MAX_CHROMS-1:0] cnt_vld_r, cnt_vld_nxt;

  seg_entry_t          nw [3];
  logic [1:0]          k;
  logic [CNT_W:0]      new_cnt;
  logic [FIELD_W:0]    init_end;
  logic [FIELD_W-1:0]  ent_l, avail;
  logic [FIELD_W:0]    q_end;
  in_item_t            in_m;
  logic                out_free;

  // Mask positions to the configured width
  always_comb begin
    in_m           = in_data;
    in_m.left_pos  = in_data.left_pos & POS_MASK;
    in_m.right_pos = in_data.right_pos & POS_MASK;
  end

  // Plan the replacement entries for the covering segment
  always_comb begin
    for (int unsigned m = 0; m < 3; m++) begin
      nw[m] = '0;
    end
    k = 2'd0;
    case (op_r)
      OP_INV: begin
        nw[0] = '{KIND_NORMAL, lp_r, os_r};
        nw[1] = '{KIND_INVERTED, lp_r - 31'd1, rp_r - 31'd1};
        nw[2] = '{KIND_NORMAL, oe_r, rp_r};
        k     = 2'd3;
      end
      OP_DEL: begin
        nw[0] = '{KIND_NORMAL, lp_r, os_r};
        nw[1] = '{KIND_NORMAL, oe_r, rp_r};
        k     = 2'd2;
      end
      OP_INS: begin
        nw[0] = '{KIND_NORMAL, lp_r, os_r};
        nw[1] = '{KIND_INSERTED, rp_r - lp_r, 31'd0};
        nw[2] = '{KIND_NORMAL, oe_r, lp_r};
        k     = 2'd3;
      end
      default: begin
        if (os_r < lp_r) begin
          nw[0] = '{KIND_NORMAL, lp_r, os_r};
          nw[1] = '{KIND_DUPLIC, rp_r, lp_r};
          k     = 2'd2;
        end else begin
          nw[0] = '{KIND_DUPLIC, rp_r, lp_r};
          k     = 2'd1;
        end
        if (lp_r < oe_r) begin
          nw[k] = '{KIND_NORMAL, oe_r, lp_r};
          k     = k + 2'd1;
        end
      end
    endcase
    new_cnt = {1'b0, n_r} + (CNT_W+1)'(k) - (CNT_W+1)'(1);
  end

  assign init_end = {1'b0, lp_r} + 32'd1;
  assign ent_l    = entry_len(seg_rdata);
  assign avail    = (ent_l >= diff_r) ? (ent_l - diff_r) : '0;
  assign q_end    = {1'b0, lp_r} + {1'b0, rp_r};
  assign out_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    base_nxt    = base_r;
    lp_nxt      = lp_r;
    rp_nxt      = rp_r;
    n_nxt       = n_r;
    i_nxt       = i_r;
    f_nxt       = f_r;
    idx_nxt     = idx_r;
    os_nxt      = os_r;
    oe_nxt      = oe_r;
    acc_nxt     = acc_r;
    qbase_nxt   = qbase_r;
    rem_nxt     = rem_r;
    diff_nxt    = diff_r;
    j_nxt       = j_r;
    more_nxt    = more_r;
    res_nxt     = res_r;
    cnt_vld_nxt = cnt_vld_r;
    mc          = '0;
    seg_waddr   = base_r;
    seg_wdata   = '0;
    seg_raddr   = base_r + ADDR_W'(i_r);
    cnt_waddr   = ch_r;
    cnt_wdata   = '0;
    cnt_raddr   = CH_W'(in_data.chrom);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_m.opcode;
          ch_nxt   = CH_W'(in_m.chrom);
          base_nxt = ADDR_W'(in_m.chrom * MAX_SEGMENTS);
          lp_nxt   = in_m.left_pos;
          rp_nxt   = in_m.right_pos;
          i_nxt    = '0;
          more_nxt = 1'b0;
          res_nxt  = '{31'd0, 31'd0, KIND_NORMAL, ST_OK, 1'b1};
          if (in_m.opcode > OP_QUERY) begin
            state_nxt = S_IDLE;
          end else if (int'(in_m.chrom) >= int'(MAX_CHROMS)) begin
            res_nxt.status = ST_NO_COVER;
            state_nxt      = S_EMIT;
          end else if (in_m.opcode == OP_INIT) begin
            state_nxt = S_INIT;
          end else begin
            mc.cnt_re = 1'b1;
            state_nxt = S_CNT;
          end
        end
      end
      S_INIT: begin
        mc.seg_we  = 1'b1;
        seg_wdata  = '{KIND_NORMAL, init_end[FIELD_W] ? FIELD_MAX : init_end[FIELD_W-1:0],
                       31'd1};
        mc.cnt_we  = 1'b1;
        cnt_wdata  = CNT_W'(1);
        cnt_vld_nxt[ch_r] = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_CNT: begin
        n_nxt = cnt_vld_r[ch_r] ? cnt_rdata : '0;
        if (op_r == OP_QUERY) begin
          acc_nxt   = '0;
          qbase_nxt = '0;
          idx_nxt   = '0;
          if (!cnt_vld_r[ch_r] || cnt_rdata == '0) begin
            res_nxt.status = ST_PAST_END;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_QRD;
          end
        end else if (lp_r >= rp_r || !cnt_vld_r[ch_r] || cnt_rdata == '0) begin
          res_nxt.status = ST_NO_COVER;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        mc.seg_re = 1'b1;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (seg_rdata.kind == KIND_NORMAL && seg_rdata.seg_start <= lp_r &&
            seg_rdata.seg_end >= rp_r) begin
          f_nxt     = i_r;
          os_nxt    = seg_rdata.seg_start;
          oe_nxt    = seg_rdata.seg_end;
          state_nxt = S_PLAN;
        end else if (i_r + CNT_W'(1) == n_r) begin
          res_nxt.status = ST_NO_COVER;
          state_nxt      = S_EMIT;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SRD;
        end
      end
      S_PLAN: begin
        j_nxt = '0;
        if (new_cnt > (CNT_W+1)'(MAX_SEGMENTS)) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_EMIT;
        end else if (k > 2'd1 && n_r > f_r + CNT_W'(1)) begin
          i_nxt     = n_r - CNT_W'(1);
          state_nxt = S_TRD;
        end else begin
          state_nxt = S_NWR;
        end
      end
      S_TRD: begin
        mc.seg_re = 1'b1;
        state_nxt = S_TWR;
      end
      S_TWR: begin
        // Move one tail entry up by k-1 places, top first
        mc.seg_we = 1'b1;
        seg_waddr = base_r + ADDR_W'(i_r) + ADDR_W'(k) - ADDR_W'(1);
        seg_wdata = seg_rdata;
        if (i_r == f_r + CNT_W'(1)) begin
          state_nxt = S_NWR;
        end else begin
          i_nxt     = i_r - CNT_W'(1);
          state_nxt = S_TRD;
        end
      end
      S_NWR: begin
        mc.seg_we = 1'b1;
        seg_waddr = base_r + ADDR_W'(f_r) + ADDR_W'(j_r);
        seg_wdata = nw[j_r];
        j_nxt     = j_r + 2'd1;
        if (j_r + 2'd1 == k) begin
          mc.cnt_we      = 1'b1;
          cnt_wdata      = new_cnt[CNT_W-1:0];
          res_nxt.status = ST_OK;
          state_nxt      = S_EMIT;
        end
      end
      S_QRD: begin
        mc.seg_re = 1'b1;
        state_nxt = S_QACC;
      end
      S_QACC: begin
        if (acc_r <= ACC_W'(lp_r)) begin
          idx_nxt   = i_r;
          qbase_nxt = acc_r;
        end
        acc_nxt = acc_r + ACC_W'(ent_l);
        if (i_r + CNT_W'(1) == n_r) begin
          state_nxt = S_QCHK;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_QRD;
        end
      end
      S_QCHK: begin
        if (ACC_W'(q_end) > acc_r) begin
          res_nxt.status = ST_PAST_END;
          state_nxt      = S_EMIT;
        end else begin
          rem_nxt   = rp_r;
          diff_nxt  = lp_r - qbase_r[FIELD_W-1:0];
          i_nxt     = idx_r;
          state_nxt = S_TRD;
          mc.seg_re = 1'b0;
          state_nxt = S_PCALC;
          mc.seg_re = 1'b0;
        end
        if (ACC_W'(q_end) <= acc_r) begin
          // Fetch the first piece's entry now
          seg_raddr = base_r + ADDR_W'(idx_r);
          mc.seg_re = 1'b1;
        end
      end
      S_PCALC: begin
        res_nxt.piece_start = seg_rdata.seg_start + diff_r;
        res_nxt.piece_kind  = seg_rdata.kind;
        res_nxt.status      = ST_OK;
        if (avail >= rem_r || i_r + CNT_W'(1) == n_r) begin
          res_nxt.piece_length = rem_r;
          res_nxt.last         = 1'b1;
          more_nxt             = 1'b0;
        end else begin
          res_nxt.piece_length = avail;
          res_nxt.last         = 1'b0;
          more_nxt             = 1'b1;
          rem_nxt              = rem_r - avail;
          diff_nxt             = '0;
          i_nxt                = i_r + CNT_W'(1);
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (more_r) begin
            // Fetch the next piece's entry
            mc.seg_re = 1'b1;
            state_nxt = S_PCALC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: load a finished beat, drop it once taken
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_EMIT && out_free) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_vld_r   <= '0;
      more_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      more_r      <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    ch_r    <= ch_nxt;
    base_r  <= base_nxt;
    lp_r    <= lp_nxt;
    rp_r    <= rp_nxt;
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    f_r     <= f_nxt;
    idx_r   <= idx_nxt;
    os_r    <= os_nxt;
    oe_r    <= oe_nxt;
    acc_r   <= acc_nxt;
    qbase_r <= qbase_nxt;
    rem_r   <= rem_nxt;
    diff_r  <= diff_nxt;
    j_r     <= j_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SMET_ASSERT_IMP(a_no_seg_rw, mc.seg_we, !mc.seg_re, "segment memory read and write together")
  `SMET_ASSERT_IMP(a_cnt_bound, mc.cnt_we, cnt_wdata <= CNT_W'(MAX_SEGMENTS), "count beyond table")
  `SMET_ASSERT_IMP(a_seg_in_tab, mc.seg_we,
                   (seg_waddr - base_r) < ADDR_W'(MAX_SEGMENTS), "write outside chromosome table")
  `SMET_ASSERT_NXT(a_emit_loads, state_r == S_EMIT && out_free, out_valid_r,
                   "result not loaded")

endmodule

@@ hdl/segment_map_edit_and_translate_top.sv @@
// Segment map editor and translator: top level.
// Holds the segment and count memories; depends on smet_pkg, smet_ram, smet_ctrl.
//
// Usage:
//   in_valid/in_ready/in_data carry one command beat (init, edit or query) for a
//   chromosome table. out_valid/out_ready/out_data return result beats; the
//   final beat of each command has last set. Init and edit give one beat, a
//   query one beat per piece, unknown opcodes none.
//   Operation: one command at a time. An edit reads the count, searches the
//   entries up to the covering one, plans, moves the tail entries up, writes
//   each new entry and registers the beat. A query sums the lengths of all
//   table entries, then computes and emits one beat per piece. The segment
//   memory, at most one access per cycle, is read then written entry by entry.
//   Reset clears the per-chromosome counts at once (valid flags); no clearing
//   pass is needed. A stalled receiver holds the result in the output register;
//   the block accepts the next command once the last beat is registered, and
//   query pieces wait in the sequencer while the output is full.
module segment_map_edit_and_translate_top
  import smet_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned MAX_CHROMS   = 32,
  parameter int unsigned POS_BITS     = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CH_W   = (MAX_CHROMS > 1) ? $clog2(MAX_CHROMS) : 1;
  localparam int unsigned ADDR_W = $clog2(MAX_CHROMS * MAX_SEGMENTS);

  mem_ctl_t          mc;
  logic [ADDR_W-1:0] seg_waddr, seg_raddr;
  seg_entry_t        seg_wdata, seg_rdata;
  logic [CH_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

  // Sequencer and result register
  smet_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .MAX_CHROMS  (MAX_CHROMS),
    .POS_BITS    (POS_BITS),
    .CNT_W       (CNT_W),
    .CH_W        (CH_W),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .mc       (mc),
    .seg_waddr(seg_waddr),
    .seg_wdata(seg_wdata),
    .seg_raddr(seg_raddr),
    .seg_rdata(seg_rdata),
    .cnt_waddr(cnt_waddr),
    .cnt_wdata(cnt_wdata),
    .cnt_raddr(cnt_raddr),
    .cnt_rdata(cnt_rdata)
  );

  // Segment entries, one table of MAX_SEGMENTS per chromosome
  smet_ram #(
    .DW   ($bits(seg_entry_t)),
    .DEPTH(MAX_CHROMS * MAX_SEGMENTS),
    .AW   (ADDR_W)
  ) u_seg_ram (
    .clk  (clk),
    .we   (mc.seg_we),
    .waddr(seg_waddr),
    .wdata(seg_wdata),
    .re   (mc.seg_re),
    .raddr(seg_raddr),
    .rdata(seg_rdata)
  );

  // Segment counts per chromosome
  smet_ram #(
    .DW   (CNT_W),
    .DEPTH(MAX_CHROMS),
    .AW   (CH_W)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (mc.cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .re   (mc.cnt_re),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

endmodule
